@@ rtl/core/ridf_pkg.sv @@
// ----------------------------------------------------------------------------
// ridf_pkg
// Shared types and constants of the recent ID duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ridf_pkg;

  // default number of history entries
  localparam int unsigned HistoryDepthDefault = 256;

  // id width of one history entry
  localparam int unsigned IdWidth = 32;

  // command codes of an input word
  typedef enum logic [1:0] {
    CMD_CHECK = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_WRITE = 6'b001000,
    ST_CLEAR = 6'b010000,
    ST_RESP  = 6'b100000
  } state_e;

endpackage : ridf_pkg

`default_nettype wire

@@ rtl/core/recent_id_duplicate_filter_top.sv @@
// ----------------------------------------------------------------------------
// recent_id_duplicate_filter_top
// History ring of recent packet ids in one synchronous memory; a check sweeps
// every entry, an add writes at the ring pointer, a clear zeroes every entry.
// ----------------------------------------------------------------------------
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, command_i,         | input
//          | packet_id_i                                |
//  out     | out_valid_o, out_ready_i, is_duplicate_o   | output
//
//  check: SCAN, DRAIN and RESP follow the accept, one memory read per
//    cycle through the single read port during SCAN
//  add: accept, write, result; unused command: accept, result
//  clear: one memory write per cycle over every entry, then result
//  reset: a clearing pass over every entry runs before the first word
//    is accepted
//  a word is accepted whenever the sequencer is idle, even while the previous
//    result waits in the output register; stalls on out hold the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module recent_id_duplicate_filter_top #(
  parameter int unsigned HISTORY_DEPTH = ridf_pkg::HistoryDepthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    command_i,
  input  wire logic [ridf_pkg::IdWidth-1:0]  packet_id_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               is_duplicate_o
);

  localparam int unsigned AddrW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(HISTORY_DEPTH - 1);

  // history memory
  logic [ridf_pkg::IdWidth-1:0] mem_q [HISTORY_DEPTH];

  ridf_pkg::state_e             state_q, state_d;
  ridf_pkg::cmd_e               cmd_q, cmd_d;
  logic [ridf_pkg::IdWidth-1:0] id_q, id_d;
  logic [AddrW-1:0]             addr_q, addr_d;
  logic [AddrW-1:0]             wp_q, wp_d;
  logic                         dup_q, dup_d;
  logic                         init_q, init_d;
  logic                         rd_valid_q, rd_valid_d;
  logic [ridf_pkg::IdWidth-1:0] rd_data_q;
  logic                         out_valid_q, out_valid_d;
  logic                         out_dup_q, out_dup_d;

  logic                         in_fire;
  logic                         out_free;
  logic                         mem_we;
  logic [AddrW-1:0]             mem_waddr;
  logic [ridf_pkg::IdWidth-1:0] mem_wdata;
  logic                         mem_re;

  assign in_ready_o     = (state_q == ridf_pkg::ST_IDLE);
  assign in_fire        = in_valid_i && in_ready_o;
  assign out_free       = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign is_duplicate_o = out_dup_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    id_d        = id_q;
    addr_d      = addr_q;
    wp_d        = wp_q;
    init_d      = init_q;
    dup_d       = dup_q | (rd_valid_q && (rd_data_q == id_q));
    rd_valid_d  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_dup_d   = out_dup_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    case (state_q)
      ridf_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd_d  = ridf_pkg::cmd_e'(command_i);
          id_d   = packet_id_i;
          dup_d  = 1'b0;
          addr_d = '0;
          case (command_i)
            ridf_pkg::CMD_CHECK: state_d = ridf_pkg::ST_SCAN;
            ridf_pkg::CMD_ADD:   state_d = ridf_pkg::ST_WRITE;
            ridf_pkg::CMD_CLEAR: state_d = ridf_pkg::ST_CLEAR;
            default:             state_d = ridf_pkg::ST_RESP;
          endcase
        end
      end
      ridf_pkg::ST_SCAN: begin
        // one read per cycle, compared in the next cycle
        mem_re     = 1'b1;
        rd_valid_d = 1'b1;
        addr_d     = addr_q + AddrW'(1);
        if (addr_q == LastAddr) begin
          state_d = ridf_pkg::ST_DRAIN;
        end
      end
      ridf_pkg::ST_DRAIN: begin
        state_d = ridf_pkg::ST_RESP;
      end
      ridf_pkg::ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = wp_q;
        mem_wdata = id_q;
        wp_d      = (wp_q == LastAddr) ? '0 : wp_q + AddrW'(1);
        state_d   = ridf_pkg::ST_RESP;
      end
      ridf_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        addr_d = addr_q + AddrW'(1);
        if (addr_q == LastAddr) begin
          addr_d  = '0;
          init_d  = 1'b0;
          state_d = init_q ? ridf_pkg::ST_IDLE : ridf_pkg::ST_RESP;
        end
      end
      ridf_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_dup_d   = dup_q;
          state_d     = ridf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ridf_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ridf_pkg::ST_CLEAR;
      init_q      <= 1'b1;
      addr_q      <= '0;
      wp_q        <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      addr_q      <= addr_d;
      wp_q        <= wp_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    id_q      <= id_d;
    dup_q     <= dup_d;
    out_dup_q <= out_dup_d;
  end

  // memory write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  // memory read port, registered data
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem_q[addr_q];
    end
  end

  // checks
  a_out_from_resp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ridf_pkg::ST_RESP))
    else $error("result presented without a response step");

  a_rd_after_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> $past(state_q == ridf_pkg::ST_SCAN))
    else $error("compare valid outside a scan");

  a_wp_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ridf_pkg::ST_WRITE) |=> (wp_q != $past(wp_q)))
    else $error("write pointer did not advance on add");

  a_no_dup_for_other : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ridf_pkg::ST_RESP && cmd_q != ridf_pkg::CMD_CHECK) |-> !dup_q)
    else $error("duplicate flag set for a non-check command");

endmodule : recent_id_duplicate_filter_top

`default_nettype wire
